// ----- rtl/core/feature_point_window_admission_defines.svh -----
// ----------------------------------------------------------------------------
// Feature point window admission - assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef FEATURE_POINT_WINDOW_ADMISSION_DEFINES_SVH
`define FEATURE_POINT_WINDOW_ADMISSION_DEFINES_SVH

// same-cycle implication
`define FPWA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FPWA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/fpwa_pkg.sv -----
// ----------------------------------------------------------------------------
// fpwa_pkg
// Constants, codes and types of the feature point window admission block.
// ----------------------------------------------------------------------------
package fpwa_pkg;

	localparam int TABLE_DEPTH = 512;
	localparam int COORD_BITS  = 16;
	localparam int FRAC_BITS   = 4;

	localparam int ADDR_W    = $clog2(TABLE_DEPTH);
	localparam int COUNT_W   = $clog2(TABLE_DEPTH + 1);
	localparam int FIELD_W   = 16;
	localparam int OPCODE_W  = 2;
	localparam int VERDICT_W = 2;
	localparam int HELD_W    = 10;
	localparam int MAXPTS_W  = 10;
	localparam int RADIUS_W  = 10;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = 1;

	localparam int SQ_W     = 2 * COORD_BITS;
	localparam int DIST_W   = SQ_W + 1;
	localparam int RAD_FX_W = RADIUS_W + FRAC_BITS;
	localparam int R2_W     = 2 * RAD_FX_W;
	localparam int CMP_W    = (DIST_W > R2_W) ? DIST_W : R2_W;
	localparam int LIM_W    = (COUNT_W > MAXPTS_W) ? COUNT_W : MAXPTS_W;

	localparam logic [MAXPTS_W-1:0] MAXPTS_RESET = MAXPTS_W'(512);
	localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(20);

	localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_TRACK = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_CAND  = 2'd2;

	localparam logic [VERDICT_W-1:0] VD_STORED = 2'd0;
	localparam logic [VERDICT_W-1:0] VD_REJECT = 2'd1;
	localparam logic [VERDICT_W-1:0] VD_FULL   = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_PT_LIMIT      = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_WINDOW_RADIUS = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_SCAN,
		ST_DRAIN,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
	} point_t;

	typedef struct packed {
		logic busy;
		logic hit_valid;
		logic hit;
	} dist_status_t;

endpackage

// ----- rtl/core/fpwa_ram.sv -----
// ----------------------------------------------------------------------------
// fpwa_ram
// Point table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fpwa_ram (
	input  logic                       clk,
	input  logic                       we,
	input  logic [fpwa_pkg::ADDR_W-1:0] waddr,
	input  fpwa_pkg::point_t           wdata,
	input  logic [fpwa_pkg::ADDR_W-1:0] raddr,
	output fpwa_pkg::point_t           rdata
);

	fpwa_pkg::point_t mem [fpwa_pkg::TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/fpwa_dist.sv -----
// ----------------------------------------------------------------------------
// fpwa_dist
// Pipelined window test: |dx|,|dy| -> squares -> sum compare with r^2.
// ----------------------------------------------------------------------------
module fpwa_dist (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         valid_in,
	input  fpwa_pkg::point_t             cand,
	input  fpwa_pkg::point_t             stored,
	input  logic [fpwa_pkg::RADIUS_W-1:0] radius,
	output fpwa_pkg::dist_status_t       status
);

	logic                           v_s2, v_s3, v_s4;
	logic [fpwa_pkg::COORD_BITS-1:0] dx_s2, dy_s2;
	logic [fpwa_pkg::SQ_W-1:0]       sqx_s3, sqy_s3;
	logic                           hit_s4;
	logic [fpwa_pkg::R2_W-1:0]       r2_q;
	logic [fpwa_pkg::RAD_FX_W-1:0]   rfx;
	logic [fpwa_pkg::DIST_W-1:0]     sum;

	assign rfx = {radius, {fpwa_pkg::FRAC_BITS{1'b0}}};
	assign sum = {1'b0, sqx_s3} + {1'b0, sqy_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s2 <= valid_in;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		r2_q   <= rfx * rfx;
		dx_s2  <= (cand.x >= stored.x) ? (cand.x - stored.x) : (stored.x - cand.x);
		dy_s2  <= (cand.y >= stored.y) ? (cand.y - stored.y) : (stored.y - cand.y);
		sqx_s3 <= dx_s2 * dx_s2;
		sqy_s3 <= dy_s2 * dy_s2;
		hit_s4 <= fpwa_pkg::CMP_W'(sum) <= fpwa_pkg::CMP_W'(r2_q);
	end

	assign status.busy      = v_s2 | v_s3 | v_s4;
	assign status.hit_valid = v_s4;
	assign status.hit       = hit_s4;

endmodule

// ----- rtl/core/feature_point_window_admission.sv -----
// ----------------------------------------------------------------------------
// feature_point_window_admission
// Point table with circular-window admission of candidate points.
// ----------------------------------------------------------------------------
// channel   direction  handshake               payload
// in        input      in_valid / in_ready     opcode, point_x, point_y
// out       output     out_valid / out_ready   verdict, points_held
// cfg       input      APB psel/penable/pready point limit, window radius
//
// Clear, tracked point and unchecked requests go from accept through the decide
// and result states to out. Checked candidate: one table read per stored point.
// One request in flight; the next is accepted while a result waits at out.
// Reset empties the table at once (count only), no clearing pass.
// ----------------------------------------------------------------------------
`include "feature_point_window_admission_defines.svh"

module feature_point_window_admission (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [fpwa_pkg::OPCODE_W-1:0]      opcode,
	input  logic [fpwa_pkg::FIELD_W-1:0]       point_x,
	input  logic [fpwa_pkg::FIELD_W-1:0]       point_y,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [fpwa_pkg::VERDICT_W-1:0]     verdict,
	output logic [fpwa_pkg::HELD_W-1:0]        points_held,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [fpwa_pkg::PADDR_W-1:0]       paddr,
	input  logic [fpwa_pkg::PDATA_W-1:0]       pwdata,
	output logic [fpwa_pkg::PDATA_W-1:0]       prdata,
	output logic                              pready
);

	fpwa_pkg::state_t state_q, state_d;

	logic [fpwa_pkg::OPCODE_W-1:0]  op_q;
	fpwa_pkg::point_t              cand_q;
	logic [fpwa_pkg::COUNT_W-1:0]   count_q, count_d;
	logic                          bypass_q;
	logic [fpwa_pkg::MAXPTS_W-1:0]  max_q;
	logic [fpwa_pkg::RADIUS_W-1:0]  radius_q;
	logic [fpwa_pkg::COUNT_W-1:0]   scan_q;
	logic                          hit_q;
	logic [fpwa_pkg::VERDICT_W-1:0] res_verdict_q, dec_verdict;
	logic                          res_store_q, dec_store;
	logic                          res_load, out_load, rd_issue, scan_start;
	logic                          rd_valid_s1;
	logic                          out_valid_q;
	logic [fpwa_pkg::VERDICT_W-1:0] out_verdict_q;
	logic [fpwa_pkg::HELD_W-1:0]    out_held_q;
	logic                          tbl_full, lim_full, cfg_wr;
	logic [fpwa_pkg::REG_IDX_W-1:0] reg_idx;
	logic                          ram_we;
	fpwa_pkg::point_t              ram_rdata;
	fpwa_pkg::dist_status_t        dist_st;

	assign in_ready  = (state_q == fpwa_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign verdict   = out_verdict_q;
	assign points_held = out_held_q;

	// config port
	assign pready  = 1'b1;
	assign reg_idx = paddr[fpwa_pkg::PADDR_W-1:2];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_comb begin
		case (reg_idx)
			fpwa_pkg::REG_PT_LIMIT:      prdata = fpwa_pkg::PDATA_W'(max_q);
			fpwa_pkg::REG_WINDOW_RADIUS: prdata = fpwa_pkg::PDATA_W'(radius_q);
			default:                     prdata = '0;
		endcase
	end

	assign tbl_full = (count_q >= fpwa_pkg::COUNT_W'(fpwa_pkg::TABLE_DEPTH));
	assign lim_full = (fpwa_pkg::LIM_W'(count_q) >= fpwa_pkg::LIM_W'(max_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fpwa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		dec_verdict = fpwa_pkg::VD_STORED;
		dec_store   = 1'b0;
		res_load    = 1'b0;
		out_load    = 1'b0;
		rd_issue    = 1'b0;
		scan_start  = 1'b0;
		case (state_q)
			fpwa_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = fpwa_pkg::ST_DECIDE;
				end
			end
			fpwa_pkg::ST_DECIDE: begin
				res_load = 1'b1;
				state_d  = fpwa_pkg::ST_RESULT;
				case (op_q)
					fpwa_pkg::OP_TRACK: begin
						if (tbl_full) begin
							dec_verdict = fpwa_pkg::VD_FULL;
						end else begin
							dec_store = 1'b1;
						end
					end
					fpwa_pkg::OP_CAND: begin
						if (tbl_full) begin
							dec_verdict = fpwa_pkg::VD_FULL;
						end else if (bypass_q) begin
							dec_store = 1'b1;
						end else if (lim_full) begin
							dec_verdict = fpwa_pkg::VD_FULL;
						end else begin
							res_load   = 1'b0;
							scan_start = 1'b1;
							state_d    = fpwa_pkg::ST_SCAN;
						end
					end
					default: begin
						dec_verdict = fpwa_pkg::VD_STORED;
					end
				endcase
			end
			fpwa_pkg::ST_SCAN: begin
				if (scan_q < count_q) begin
					rd_issue = 1'b1;
				end else begin
					state_d = fpwa_pkg::ST_DRAIN;
				end
			end
			fpwa_pkg::ST_DRAIN: begin
				if (!rd_valid_s1 && !dist_st.busy) begin
					res_load = 1'b1;
					state_d  = fpwa_pkg::ST_RESULT;
					if (hit_q) begin
						dec_verdict = fpwa_pkg::VD_REJECT;
					end else begin
						dec_store = 1'b1;
					end
				end
			end
			fpwa_pkg::ST_RESULT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = fpwa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fpwa_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		count_d = count_q;
		if (op_q == fpwa_pkg::OP_CLEAR) begin
			count_d = '0;
		end else if (res_store_q) begin
			count_d = count_q + 1'b1;
		end
	end

	assign ram_we = out_load & res_store_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			bypass_q    <= 1'b1;
			max_q       <= fpwa_pkg::MAXPTS_RESET;
			radius_q    <= fpwa_pkg::RADIUS_RESET;
			out_valid_q <= 1'b0;
			rd_valid_s1 <= 1'b0;
			scan_q      <= '0;
			hit_q       <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (reg_idx)
					fpwa_pkg::REG_PT_LIMIT:      max_q    <= pwdata[fpwa_pkg::MAXPTS_W-1:0];
					fpwa_pkg::REG_WINDOW_RADIUS: radius_q <= pwdata[fpwa_pkg::RADIUS_W-1:0];
					default:                     ;
				endcase
			end
			rd_valid_s1 <= rd_issue;
			if (scan_start) begin
				scan_q <= '0;
				hit_q  <= 1'b0;
			end else begin
				if (rd_issue) begin
					scan_q <= scan_q + 1'b1;
				end
				if (dist_st.hit_valid && dist_st.hit) begin
					hit_q <= 1'b1;
				end
			end
			if (out_load) begin
				count_q <= count_d;
				if (op_q == fpwa_pkg::OP_CLEAR) begin
					bypass_q <= 1'b1;
				end else if (op_q == fpwa_pkg::OP_TRACK) begin
					bypass_q <= 1'b0;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q     <= opcode;
			cand_q.x <= point_x[fpwa_pkg::COORD_BITS-1:0];
			cand_q.y <= point_y[fpwa_pkg::COORD_BITS-1:0];
		end
		if (res_load) begin
			res_verdict_q <= dec_verdict;
			res_store_q   <= dec_store;
		end
		if (out_load) begin
			out_verdict_q <= res_verdict_q;
			out_held_q    <= fpwa_pkg::HELD_W'(count_d);
		end
	end

	fpwa_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[fpwa_pkg::ADDR_W-1:0]),
		.wdata (cand_q),
		.raddr (scan_q[fpwa_pkg::ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	fpwa_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_in (rd_valid_s1),
		.cand     (cand_q),
		.stored   (ram_rdata),
		.radius   (radius_q),
		.status   (dist_st)
	);

	`FPWA_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= fpwa_pkg::COUNT_W'(fpwa_pkg::TABLE_DEPTH), "point count above table depth")
	`FPWA_ASSERT_NOW(a_write_room, clk, arst_n, ram_we, !tbl_full, "table write with full table")
	`FPWA_ASSERT_NOW(a_idle_quiet, clk, arst_n, state_q == fpwa_pkg::ST_IDLE, !rd_valid_s1 && !dist_st.busy, "scan pipeline busy while idle")
	`FPWA_ASSERT_NEXT(a_reject_checked, clk, arst_n, res_load && dec_verdict == fpwa_pkg::VD_REJECT, !bypass_q && op_q == fpwa_pkg::OP_CAND, "reject outside a checked candidate")

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for feature_point_window_admission. Requests go in
// through the valid/ready port, and registers are written over APB while the
// block is idle. Every accepted request is run through a table model in the
// ledger class, which queues the verdict and count that the block must return.
// Results are compared in order as they are taken. Both sides stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import fpwa_pkg::*;

	localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 80;
	localparam int QUIET_TAIL   = 30;

	typedef struct packed {
		logic [VERDICT_W-1:0] verdict;
		logic [HELD_W-1:0]    held;
	} outcome_t;

	class admission_ledger;
		logic [COORD_BITS-1:0] held_x [TABLE_DEPTH];
		logic [COORD_BITS-1:0] held_y [TABLE_DEPTH];
		int held_count;
		bit bypass;
		int max_pts;
		int radius;
		outcome_t due [$];
		int failures;

		function new();
			held_count = 0;
			bypass = 1'b1;
			max_pts = MAXPTS_RESET;
			radius = RADIUS_RESET;
			failures = 0;
		endfunction

		function void set_register(input logic [REG_IDX_W-1:0] idx, input int value);
			if (idx == REG_PT_LIMIT) begin
				max_pts = value & 'h3ff;
			end else begin
				radius = value & 'h3ff;
			end
		endfunction

		// squared distance against squared radius, 1/256 pixel^2 units
		function bit in_window(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y);
			longint r2;
			longint dx;
			longint dy;
			r2 = (longint'(radius) * 16) * (longint'(radius) * 16);
			for (int k = 0; k < held_count; k++) begin
				dx = (held_x[k] >= x) ? longint'(held_x[k]) - longint'(x)
					: longint'(x) - longint'(held_x[k]);
				dy = (held_y[k] >= y) ? longint'(held_y[k]) - longint'(y)
					: longint'(y) - longint'(held_y[k]);
				if (dx * dx + dy * dy <= r2)
					return 1'b1;
			end
			return 1'b0;
		endfunction

		function void put_point(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y);
			if (held_count < TABLE_DEPTH) begin
				held_x[held_count] = x;
				held_y[held_count] = y;
				held_count++;
			end
		endfunction

		function void note_request(input logic [OPCODE_W-1:0] op,
				input logic [FIELD_W-1:0] x, input logic [FIELD_W-1:0] y);
			logic [VERDICT_W-1:0] v;
			outcome_t o;
			v = VD_STORED;
			case (op)
				OP_CLEAR: begin
					held_count = 0;
					bypass = 1'b1;
				end
				OP_TRACK: begin
					bypass = 1'b0;
					if (held_count >= TABLE_DEPTH)
						v = VD_FULL;
					else
						put_point(x, y);
				end
				OP_CAND: begin
					if (held_count >= TABLE_DEPTH)
						v = VD_FULL;
					else if (bypass)
						put_point(x, y);
					else if (held_count >= max_pts)
						v = VD_FULL;
					else if (in_window(x, y))
						v = VD_REJECT;
					else
						put_point(x, y);
				end
				default: ;
			endcase
			o.verdict = v;
			o.held = HELD_W'(held_count);
			due.insert(due.size(), o);
		endfunction

		function void check_result(input logic [VERDICT_W-1:0] v, input logic [HELD_W-1:0] h);
			outcome_t want;
			if (due.size() == 0) begin
				$error("result with no request outstanding: verdict %0d points_held %0d", v, h);
				failures++;
				return;
			end
			want = due.pop_front();
			if (v !== want.verdict) begin
				$error("verdict expected %0d actual %0d", want.verdict, v);
				failures++;
			end
			if (h !== want.held) begin
				$error("points_held expected %0d actual %0d", want.held, h);
				failures++;
			end
		endfunction

		function int pending();
			return due.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [OPCODE_W-1:0] opcode = OP_CLEAR;
	logic [FIELD_W-1:0] point_x = '0;
	logic [FIELD_W-1:0] point_y = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [VERDICT_W-1:0] verdict;
	logic [HELD_W-1:0] points_held;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	admission_ledger ledger;
	bit quiet = 1'b0;
	bit calm = 1'b0;
	int random_items = 0;
	int stall_left = 0;

	feature_point_window_admission dut (.*);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			ledger.check_result(verdict, points_held);
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 15);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	initial begin
		#60_000_000;
		$display("tb NOT OK");
		$finish;
	end

	task automatic send_request(input logic [OPCODE_W-1:0] op,
			input logic [FIELD_W-1:0] x, input logic [FIELD_W-1:0] y);
		if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		point_x <= x;
		point_y <= y;
		do @(posedge clk); while (!in_ready);
		ledger.note_request(op, x, y);
	endtask

	task automatic write_register(input logic [REG_IDX_W-1:0] idx, input int value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= PDATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		ledger.set_register(idx, value);
	endtask

	task automatic configure(input int mp, input int rad);
		write_register(REG_PT_LIMIT, mp);
		write_register(REG_WINDOW_RADIUS, rad);
	endtask

	// all results back before any register write
	task automatic settle();
		in_valid <= 1'b0;
		while (ledger.pending() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	function automatic logic [FIELD_W-1:0] jitter(input logic [FIELD_W-1:0] c, input int span);
		int off;
		off = int'($urandom_range(0, 2 * span)) - span;
		return FIELD_W'(int'(c) + off);
	endfunction

	task automatic fill_table();
		logic [FIELD_W-1:0] lx;
		logic [FIELD_W-1:0] ly;
		configure(TABLE_DEPTH, 0);
		send_request(OP_CLEAR, '0, '0);
		// unchecked run up to two short of the physical limit
		repeat (TABLE_DEPTH - 2) send_request(OP_CAND, FIELD_W'($urandom), FIELD_W'($urandom));
		lx = FIELD_W'($urandom);
		ly = FIELD_W'($urandom);
		send_request(OP_TRACK, lx, ly);
		// zero radius: only an exact duplicate is inside
		send_request(OP_CAND, lx, ly);
		repeat (2) send_request(OP_CAND, FIELD_W'($urandom), FIELD_W'($urandom));
		send_request(OP_TRACK, FIELD_W'($urandom), FIELD_W'($urandom));
		send_request(OP_UNUSED, FIELD_W'($urandom), FIELD_W'($urandom));
		send_request(OP_CLEAR, '1, '1);
		settle();
	endtask

	task automatic random_phase();
		logic [FIELD_W-1:0] ax [$];
		logic [FIELD_W-1:0] ay [$];
		logic [FIELD_W-1:0] x;
		logic [FIELD_W-1:0] y;
		logic [OPCODE_W-1:0] op;
		int mp;
		int rad;
		int span;
		int base_x;
		int base_y;
		int pick;
		case ($urandom_range(0, 4))
			0: mp = 1;
			1: mp = TABLE_DEPTH;
			2: mp = $urandom_range(1, 32);
			default: mp = $urandom_range(1, TABLE_DEPTH);
		endcase
		case ($urandom_range(0, 4))
			0: rad = 0;
			1: rad = 1023;
			2: rad = RADIUS_RESET;
			3: rad = $urandom_range(0, 1023);
			default: rad = $urandom_range(1, 60);
		endcase
		configure(mp, rad);
		calm = ($urandom_range(0, 3) == 0);
		span = rad * 16 + 24;
		base_x = $urandom_range(0, 65535);
		base_y = $urandom_range(0, 65535);
		if ($urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(10, 30)) begin
				op = OPCODE_W'($urandom_range(0, 3));
				send_request(op, FIELD_W'($urandom), FIELD_W'($urandom));
				if (op != OP_UNUSED)
					random_items++;
			end
		end else begin
			send_request(OP_CLEAR, FIELD_W'($urandom), FIELD_W'($urandom));
			random_items++;
			repeat (($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 24)) begin
				x = FIELD_W'(base_x + $urandom_range(0, 4 * span));
				y = FIELD_W'(base_y + $urandom_range(0, 4 * span));
				send_request(OP_TRACK, x, y);
				ax.insert(ax.size(), x);
				ay.insert(ay.size(), y);
				random_items++;
			end
			repeat ($urandom_range(1, 32)) begin
				if (ax.size() != 0 && $urandom_range(0, 3) != 0) begin
					pick = $urandom_range(0, ax.size() - 1);
					x = jitter(ax[pick], span);
					y = jitter(ay[pick], span);
				end else begin
					x = FIELD_W'(base_x + $urandom_range(0, 4 * span));
					y = FIELD_W'(base_y + $urandom_range(0, 4 * span));
				end
				case ($urandom_range(0, 31))
					0: op = OP_CLEAR;
					1: op = OP_UNUSED;
					2: op = OP_TRACK;
					default: op = OP_CAND;
				endcase
				send_request(op, x, y);
				if (op != OP_CLEAR) begin
					ax.insert(ax.size(), x);
					ay.insert(ay.size(), y);
				end
				if (op != OP_UNUSED)
					random_items++;
			end
		end
		settle();
		calm = 1'b0;
	endtask

	initial begin
		ledger = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings, empty table: unchecked, duplicates accepted
		send_request(OP_CAND, 16'h0000, 16'h0000);
		send_request(OP_CAND, 16'hffff, 16'hffff);
		send_request(OP_CAND, 16'h0000, 16'h0000);
		send_request(OP_UNUSED, 16'h1234, 16'hfedc);
		send_request(OP_TRACK, 16'h8000, 16'h8000);
		// radius 20 px = 320 units, boundary counts as inside
		send_request(OP_CAND, 16'h8000 + 16'd320, 16'h8000);
		send_request(OP_CAND, 16'h8000 + 16'd321, 16'h8000);
		send_request(OP_CAND, 16'h8000 + 16'd226, 16'h8000 - 16'd226);
		send_request(OP_CAND, 16'h8000 - 16'd227, 16'h8000 + 16'd226);
		send_request(OP_CLEAR, 16'hffff, 16'h0000);
		settle();

		configure(1, 0);
		send_request(OP_TRACK, 16'd100, 16'd100);
		send_request(OP_CAND, 16'd100, 16'd100);
		settle();
		write_register(REG_PT_LIMIT, 2);
		send_request(OP_CAND, 16'd100, 16'd100);
		send_request(OP_CAND, 16'd101, 16'd100);
		send_request(OP_CAND, 16'd500, 16'd500);
		settle();

		configure(TABLE_DEPTH, 1023);
		send_request(OP_CLEAR, '0, '0);
		send_request(OP_TRACK, 16'h0000, 16'h0000);
		send_request(OP_CAND, 16'd16368, 16'h0000);
		send_request(OP_CAND, 16'd16369, 16'h0000);
		send_request(OP_CAND, 16'hffff, 16'hffff);
		send_request(OP_UNUSED, 16'hffff, 16'hffff);
		send_request(OP_CLEAR, '0, '0);
		send_request(OP_CAND, 16'd8, 16'd8);
		send_request(OP_TRACK, 16'd8, 16'd8);
		send_request(OP_CAND, 16'd8, 16'd8);
		settle();

		fill_table();

		while (random_items < RANDOM_ITEMS) begin
			quiet = (random_items >= RANDOM_ITEMS - QUIET_TAIL);
			random_phase();
		end

		repeat (TABLE_DEPTH + 16) @(posedge clk);
		if (ledger.failures == 0 && ledger.pending() == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
